/* rtl/utt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int UNIT_W  = 16;
    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int JOB_MAX = 6;     // held surrogate (3) plus current unit (3)
    localparam int CNT_W   = $clog2(JOB_MAX + 1);
    localparam int IDX_W   = $clog2(JOB_MAX);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [UNIT_W-1:0] HIGH_MIN = 16'hd800;
    localparam logic [UNIT_W-1:0] HIGH_MAX = 16'hdbff;
    localparam logic [UNIT_W-1:0] LOW_MIN  = 16'hdc00;
    localparam logic [UNIT_W-1:0] LOW_MAX  = 16'hdfff;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [CP_W-1:0] MAX_1B    = 21'h00007f;
    localparam logic [CP_W-1:0] MAX_2B    = 21'h0007ff;
    localparam logic [CP_W-1:0] MAX_3B    = 21'h00ffff;

    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hf0;
    localparam logic [BYTE_W-1:0] CONT    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_M  = 8'h3f;

    localparam logic [CNT_W-1:0] LEN_1B   = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2B   = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3B   = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4B   = 3'd4;

    typedef struct packed {
        logic [3:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]       cnt;
    } t_enc;

    // Bytes of one transaction of the front end, in emission order.
    typedef struct packed {
        logic [JOB_MAX-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               cnt;
        logic                           last;
    } t_job;

    function automatic logic is_high(input logic [UNIT_W-1:0] u);
        return (u >= HIGH_MIN) && (u <= HIGH_MAX);
    endfunction

    function automatic logic is_low(input logic [UNIT_W-1:0] u);
        return (u >= LOW_MIN) && (u <= LOW_MAX);
    endfunction

    function automatic t_enc encode(input logic [CP_W-1:0] cp);
        t_enc e;
        e = '0;
        if (cp <= MAX_1B) begin
            e.bytes[0] = cp[7:0];
            e.cnt      = LEN_1B;
        end else if (cp <= MAX_2B) begin
            e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.bytes[1] = CONT | ({2'b00, cp[5:0]} & CONT_M);
            e.cnt      = LEN_2B;
        end else if (cp <= MAX_3B) begin
            e.bytes[0] = LEAD_3B | {4'h0, cp[15:12]};
            e.bytes[1] = CONT | ({2'b00, cp[11:6]} & CONT_M);
            e.bytes[2] = CONT | ({2'b00, cp[5:0]} & CONT_M);
            e.cnt      = LEN_3B;
        end else begin
            e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT | ({2'b00, cp[17:12]} & CONT_M);
            e.bytes[2] = CONT | ({2'b00, cp[11:6]} & CONT_M);
            e.bytes[3] = CONT | ({2'b00, cp[5:0]} & CONT_M);
            e.cnt      = LEN_4B;
        end
        return e;
    endfunction

endpackage

/* rtl/utt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_front
// Accepts code units, tracks a held high surrogate and turns each transaction
// into the list of UTF-8 bytes it produces.
// ----------------------------------------------------------------------------
module utt_front
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_last_unit,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output t_job              o_job
);

    logic [UNIT_W-1:0] r_held;
    logic              r_held_valid;

    logic        accept;
    logic        unit_high;
    logic        pair;
    logic        hold_now;
    logic [CP_W-1:0] pair_cp;
    t_enc        e_pair;
    t_enc        e_held;
    t_enc        e_unit;
    t_job        n_job;

    assign o_stall   = i_full;
    assign accept    = i_valid && !i_full;
    assign unit_high = is_high(i_code_unit);
    assign pair      = r_held_valid && is_low(i_code_unit);
    assign hold_now  = !pair && unit_high && !i_last_unit;

    // held is in the high range, unit in the low range: offsets are the low 10 bits
    assign pair_cp = SUPP_BASE + {1'b0, r_held[9:0], i_code_unit[9:0]};
    assign e_pair  = encode(pair_cp);
    assign e_held  = encode({5'b00000, r_held});
    assign e_unit  = encode({5'b00000, i_code_unit});

    always_comb begin
        n_job      = '0;
        n_job.last = i_last_unit;
        if (pair) begin
            n_job.bytes[3:0] = e_pair.bytes;
            n_job.cnt        = e_pair.cnt;
        end else if (r_held_valid) begin
            // held surrogate always encodes to three bytes
            n_job.bytes[2:0] = e_held.bytes[2:0];
            n_job.bytes[5:3] = e_unit.bytes[2:0];
            n_job.cnt        = unit_high && !i_last_unit ? LEN_3B : LEN_3B + e_unit.cnt;
        end else if (!hold_now) begin
            n_job.bytes[3:0] = e_unit.bytes;
            n_job.cnt        = e_unit.cnt;
        end
    end

    assign o_job  = n_job;
    assign o_push = accept && (n_job.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held       <= '0;
        end else if (accept) begin
            r_held_valid <= hold_now;
            r_held       <= hold_now ? i_code_unit : '0;
        end
    end

endmodule

/* rtl/utt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_queue
// Small FIFO of byte lists between the front and back ends.
// ----------------------------------------------------------------------------
module utt_queue
    import utt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/utt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_back
// Walks the head byte list one byte per cycle into the output register, while the
// output register is free (not holding a byte under i_stall).
module utt_back
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run,
    output logic              o_string_end
);

    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last_of_run;
    logic              r_string_end;

    logic out_free;
    logic adv;
    logic last_b;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = !i_empty && out_free;
    assign last_b   = (CNT_W'(r_idx) == i_head.cnt - LEN_1B);
    assign o_pop    = adv && last_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_idx       <= last_b ? '0 : r_idx + 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte        <= i_head.bytes[r_idx];
            r_last_of_run <= last_b;
            r_string_end  <= last_b && i_head.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last_of_run;
    assign o_string_end  = r_string_end;

endmodule

/* rtl/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
// A unit accepted by the front end reaches the outputs through the queue write, then the
// output register; a high surrogate not ending the string waits for the next unit.
// Throughput: one byte per cycle while i_stall is low; a unit makes 0 to 6 bytes (three
// for typical non-ASCII text), a two-entry queue decouples the front. Reset (synchronous,
// active low) empties the queue, drops the output byte and any held high surrogate.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streams UTF-16 code units in and UTF-8 bytes out, pairing surrogates.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_last_unit,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run,
    output logic              o_string_end
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    utt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_full      (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    utt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    utt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_string_end  (o_string_end)
    );

endmodule

/* rtl/utt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_checker
// Port-level checks of the transcoder output stream.
// ----------------------------------------------------------------------------
module utt_checker
    import utt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_last_of_run,
    input logic              o_string_end
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_string_end))
        else $error("output changed while stalled");

    a_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_end |-> o_last_of_run)
        else $error("string end not on last byte of a run");

    // a run never ends on a lead byte
    a_run_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |-> o_out_byte[7:6] != 2'b11)
        else $error("run ends on a lead byte");

    // ASCII bytes always stand alone
    a_mid_not_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_out_byte[7])
        else $error("ASCII byte inside a multibyte run");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (.*);

/* dv/utf8_byte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_checker
// Watches both channels of the transcoder. It predicts the UTF-8 bytes of every
// accepted code unit, pairing surrogates the same way the block must. Each byte
// that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_byte_checker
    import utt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_last_unit,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_out_byte,
    input  logic              i_last_of_run,
    input  logic              i_string_end,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_bytes_checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              str_end;
    } t_utf8_byte;

    t_utf8_byte        expected_bytes[$];
    logic [BYTE_W-1:0] run_bytes[$];
    logic [UNIT_W-1:0] held_hi;
    logic              held_vld;
    int                fail_cnt;
    int                checked_cnt;

    initial begin
        held_hi         = '0;
        held_vld        = 1'b0;
        fail_cnt        = 0;
        checked_cnt     = 0;
        o_fail_count    = 0;
        o_pending       = 0;
        o_bytes_checked = 0;
    end

    function automatic void add_run_byte(input logic [BYTE_W-1:0] x);
        run_bytes.insert(run_bytes.size(), x);
    endfunction

    function automatic void emit_utf8(input logic [CP_W-1:0] cp);
        if (cp <= MAX_1B) begin
            add_run_byte(cp[7:0]);
        end else if (cp <= MAX_2B) begin
            add_run_byte(LEAD_2B | {3'b000, cp[10:6]});
            add_run_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp <= MAX_3B) begin
            add_run_byte(LEAD_3B | {4'h0, cp[15:12]});
            add_run_byte(CONT | {2'b00, cp[11:6]});
            add_run_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            add_run_byte(LEAD_4B | {5'b00000, cp[20:18]});
            add_run_byte(CONT | {2'b00, cp[17:12]});
            add_run_byte(CONT | {2'b00, cp[11:6]});
            add_run_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    task automatic predict_unit(input logic [UNIT_W-1:0] unit, input logic last);
        logic [9:0]     hi_off;
        logic [9:0]     lo_off;
        logic [CP_W-1:0] cp;
        logic           unit_hi;
        logic           unit_lo;
        t_utf8_byte     b;
        unit_hi = (unit >= HIGH_MIN) && (unit <= HIGH_MAX);
        unit_lo = (unit >= LOW_MIN) && (unit <= LOW_MAX);
        run_bytes.delete();
        if (held_vld && unit_lo) begin
            hi_off   = 10'(held_hi - HIGH_MIN);
            lo_off   = 10'(unit - LOW_MIN);
            cp       = SUPP_BASE + CP_W'({hi_off, lo_off});
            held_vld = 1'b0;
            held_hi  = '0;
            emit_utf8(cp);
        end else begin
            // a held surrogate with no partner goes out alone first
            if (held_vld) begin
                emit_utf8(CP_W'(held_hi));
                held_vld = 1'b0;
                held_hi  = '0;
            end
            if (unit_hi && !last) begin
                held_hi  = unit;
                held_vld = 1'b1;
            end else begin
                emit_utf8(CP_W'(unit));
            end
        end
        for (int k = 0; k < run_bytes.size(); k++) begin
            b.data    = run_bytes[k];
            b.run_end = (k == run_bytes.size() - 1);
            b.str_end = b.run_end && last;
            expected_bytes.insert(expected_bytes.size(), b);
        end
    endtask

    task automatic check_byte();
        t_utf8_byte exp_b;
        if (expected_bytes.size() == 0) begin
            $error("out_byte: expected nothing, got 0x%02h", i_out_byte);
            fail_cnt++;
        end else begin
            exp_b = expected_bytes.pop_front();
            if (i_out_byte !== exp_b.data) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", exp_b.data, i_out_byte);
                fail_cnt++;
            end
            if (i_last_of_run !== exp_b.run_end) begin
                $error("last_of_run: expected %0b, got %0b", exp_b.run_end, i_last_of_run);
                fail_cnt++;
            end
            if (i_string_end !== exp_b.str_end) begin
                $error("string_end: expected %0b, got %0b", exp_b.str_end, i_string_end);
                fail_cnt++;
            end
        end
        checked_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            held_hi  = '0;
            held_vld = 1'b0;
        end else begin
            // a byte leaving now can never come from a unit taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                check_byte();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_unit(i_code_unit, i_last_unit);
            end
        end
        o_pending       <= expected_bytes.size();
        o_fail_count    <= fail_cnt;
        o_bytes_checked <= checked_cnt;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives UTF-16 strings into the transcoder: directed corner units first, then
// random strings rich in surrogates, with random idling on both sides, a long
// output hold-off and drain pauses. The checker does all the comparing.
// ----------------------------------------------------------------------------
module tb;
    import utt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_OFF_LEN = 200;
    localparam int IDLE_PCT     = 18;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [UNIT_W-1:0] i_code_unit   = '0;
    logic              i_last_unit   = 1'b0;
    logic              i_stall       = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last_of_run;
    logic              o_string_end;

    logic              idle_en        = 1'b1;
    logic              start_hold_off = 1'b0;
    int                hold_off_left  = 0;
    int                cycle_cnt      = 0;
    int                units_sent     = 0;
    int                strings_sent   = 0;
    int                fail_count;
    int                pending;
    int                bytes_checked;

    always #5 i_clk = ~i_clk;

    utf16_to_utf8_transcoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_code_unit   (i_code_unit),
        .i_last_unit   (i_last_unit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_string_end  (o_string_end)
    );

    utf8_byte_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_code_unit     (i_code_unit),
        .i_last_unit     (i_last_unit),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_last_of_run   (o_last_of_run),
        .i_string_end    (o_string_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    // Output side backpressure; a hold-off request wins over random stalls.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall       <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else if (start_hold_off) begin
            i_stall       <= 1'b1;
            hold_off_left <= HOLD_OFF_LEN;
        end else if (!idle_en) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One transaction on the input channel; returns at the accepting edge.
    task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic last);
        int gap;
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= unit;
        i_last_unit <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        units_sent++;
        if (last) strings_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [UNIT_W-1:0] random_unit();
        logic [UNIT_W-1:0] u;
        case ($urandom_range(6))
            0:       u = UNIT_W'($urandom_range(16'h0000, 16'h007f));
            1:       u = UNIT_W'($urandom_range(16'h0080, 16'h07ff));
            2:       u = UNIT_W'($urandom_range(16'h0800, 16'hd7ff));
            3:       u = UNIT_W'($urandom_range(16'he000, 16'hffff));
            4:       u = UNIT_W'($urandom_range(HIGH_MIN, HIGH_MAX));
            5:       u = UNIT_W'($urandom_range(LOW_MIN, LOW_MAX));
            default: u = UNIT_W'($urandom);
        endcase
        return u;
    endfunction

    // Random strings of 1 to 9 units; most carry well-formed surrogate pairs.
    task automatic send_random_strings(input int n_units);
        logic [UNIT_W-1:0] str[$];
        int                target;
        int                str_len;
        target = units_sent + n_units;
        while (units_sent < target) begin
            str.delete();
            str_len = $urandom_range(1, 8);
            while (str.size() < str_len) begin
                if ($urandom_range(99) < 40) begin
                    str.insert(str.size(), UNIT_W'($urandom_range(HIGH_MIN, HIGH_MAX)));
                    str.insert(str.size(), UNIT_W'($urandom_range(LOW_MIN, LOW_MAX)));
                end else begin
                    str.insert(str.size(), random_unit());
                end
            end
            for (int k = 0; k < str.size(); k++) begin
                send_unit(str[k], k == str.size() - 1);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encoding length boundaries
        send_unit(16'h0000, 1'b1);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hffff, 1'b1);
        // pairs at both range ends
        send_unit(HIGH_MIN, 1'b0);
        send_unit(LOW_MIN,  1'b0);
        send_unit(HIGH_MAX, 1'b0);
        send_unit(LOW_MAX,  1'b1);
        // held high followed by a non-low unit, and by another high
        send_unit(HIGH_MIN, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(HIGH_MAX, 1'b0);
        send_unit(HIGH_MIN, 1'b0);
        send_unit(LOW_MIN,  1'b1);
        // high surrogate that ends the string
        send_unit(16'hd9ab, 1'b1);
        // unpaired lows
        send_unit(LOW_MIN,  1'b0);
        send_unit(LOW_MAX,  1'b1);
        // held high then a closing unit: four, then six bytes from one unit
        send_unit(HIGH_MIN, 1'b0);
        send_unit(16'h0041, 1'b1);
        send_unit(HIGH_MIN, 1'b0);
        send_unit(HIGH_MAX, 1'b1);
        wait_drained();

        send_random_strings(110);

        // calm stretch, no idling on either side
        idle_en <= 1'b0;
        send_random_strings(50);

        // long output hold-off while the input keeps offering units
        start_hold_off <= 1'b1;
        @(posedge i_clk);
        start_hold_off <= 1'b0;
        send_random_strings(40);
        idle_en <= 1'b1;
        wait_drained();

        send_random_strings(80);
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d code units in %0d strings: length boundaries, surrogate pairs,",
                 units_sent, strings_sent);
        $display("lone and trailing surrogates, hold-off and idling; %0d bytes compared.",
                 bytes_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
